@@ sv/fta_pkg.sv @@
// Shared types and register indexes for the flight timer and battery alarm.
package fta_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_CONDITION  = 3'd0,
        CFG_ALARM_LIMIT      = 3'd1,
        CFG_TIMER_PRESET     = 3'd2,
        CFG_BATTERY_CAL_LOW  = 3'd3,
        CFG_BATTERY_CAL_HIGH = 3'd4,
        CFG_VOLTAGE_WARNING  = 3'd5,
        CFG_ALARM_BEEP_STYLE = 3'd6
    } cfg_index_t;

    // Input opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_RELOAD = 1'b1;

    // One input request
    typedef struct packed {
        logic              opcode;
        logic signed [7:0] throttle;
        logic              run_switch;
        logic [9:0]        battery_raw;
    } item_t;

    // One result
    typedef struct packed {
        logic [15:0]        timer_value;
        logic               counting;
        logic               timer_beep;
        logic               voltage_checked;
        logic               voltage_low;
        logic signed [15:0] battery_centivolts;
        logic [7:0]         beep_style;
        logic               backlight_on;
    } result_t;

    // Controller state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_PUSH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic fin;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_last;
    } dp_status_t;

endpackage

@@ sv/fta_if.sv @@
// Handshake channel interfaces: input requests, results and configuration writes.
interface fta_item_if;
    logic          valid;
    logic          ready;
    fta_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fta_result_if;
    logic             valid;
    logic             ready;
    fta_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fta_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fta_pkg::CFG_IDX_W-1:0]      index;
    logic [fta_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/fta_ctrl.sv @@
// Controller state machine: sequences accept, multiply, serial divide and result hand-off.
module fta_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_ready,
    output logic                  out_valid,
    input  fta_pkg::dp_status_t   status,
    output fta_pkg::ctrl_cmd_t    cmd
);

    fta_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fta_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fta_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = status.need_div ? fta_pkg::ST_MUL : fta_pkg::ST_PUSH;
            end
            fta_pkg::ST_MUL:
                state_next = fta_pkg::ST_DIV;
            fta_pkg::ST_DIV:
            begin
                if (status.div_last)
                    state_next = fta_pkg::ST_FIN;
            end
            fta_pkg::ST_FIN:
                state_next = fta_pkg::ST_PUSH;
            fta_pkg::ST_PUSH:
            begin
                if (slot_free)
                    state_next = fta_pkg::ST_IDLE;
            end
            default:
                state_next = fta_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            fta_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            fta_pkg::ST_MUL:
                cmd.mul_load = 1'b1;
            fta_pkg::ST_DIV:
                cmd.div_step = 1'b1;
            fta_pkg::ST_FIN:
                cmd.fin = 1'b1;
            fta_pkg::ST_PUSH:
                cmd.load_out = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/fta_dp.sv @@
// Datapath: configuration registers, timer and alarm state, voltage multiply and serial divider.
module fta_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fta_pkg::ctrl_cmd_t               cmd,
    output fta_pkg::dp_status_t              status,
    input  fta_pkg::item_t                   in_data,
    input  logic                             cfg_we,
    input  logic [fta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fta_pkg::CFG_DATA_W-1:0]   cfg_data,
    output fta_pkg::result_t                 out_data
);

    localparam int NUM_W    = 20;
    localparam int DEN_W    = 10;
    localparam int CNT_W    = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
    localparam logic [2:0]  VC_RELOAD = 3'd5;
    localparam logic [NUM_W-1:0] SCALE = NUM_W'(700);
    localparam logic signed [21:0] OFFSET = 22'sd500;
    localparam logic signed [21:0] SAT_MAX = 22'sd32767;
    localparam logic signed [21:0] SAT_MIN = -22'sd32768;
    localparam logic [7:0] COND_RUN = 8'd200;
    localparam logic [7:0] COND_PCT_MAX = 8'd100;

    // Remainder of an 8-bit value by three is zero (reciprocal multiply)
    function automatic logic mod3_zero(input logic [7:0] x);
        logic [16:0] p;
        logic [7:0]  q;
        logic [9:0]  r;
        begin
            p = {9'd0, x} * 17'd171;
            q = p[16:9];
            r = {2'd0, x} - ({2'd0, q} + {1'b0, q, 1'b0});
            mod3_zero = (r == 10'd0);
        end
    endfunction

    // Configuration registers
    logic [7:0]  cond_reg;
    logic [15:0] limit_reg;
    logic [15:0] preset_reg;
    logic [9:0]  cal_low_reg;
    logic [9:0]  cal_high_reg;
    logic [7:0]  warn_reg;
    logic [7:0]  style_reg;

    // Block state
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  alarm_reg, alarm_next;
    logic [2:0]  vc_reg, vc_next;

    // Working registers
    fta_pkg::result_t res_reg, res_next;
    fta_pkg::result_t out_reg;
    logic [9:0]       raw_reg;
    logic [NUM_W-1:0] nq_reg;
    logic [DEN_W-1:0] dm_reg;
    logic [DEN_W-1:0] rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Tick evaluation
    logic signed [8:0] thr_sum;
    logic [7:0]        pct;
    logic              cond_ok;
    logic              counting;
    logic [15:0]       timer_dec;
    logic [7:0]        alarm_inc;
    logic              tbeep;
    logic [2:0]        vc_dec;
    logic              cal_equal;

    // Multiply stage
    logic signed [10:0] diff;
    logic signed [10:0] den;
    logic [DEN_W-1:0]   diff_mag;
    logic [DEN_W-1:0]   den_mag;
    logic [NUM_W-1:0]   prod;

    // Divide step
    logic [DEN_W:0]   trial;
    logic             qbit;

    // Finish stage
    logic signed [21:0] qs;
    logic signed [21:0] v;
    logic signed [15:0] cv;
    logic [11:0]        warn10;
    logic               vlow;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_reg     <= 8'd0;
            limit_reg    <= 16'd0;
            preset_reg   <= 16'd0;
            cal_low_reg  <= 10'd385;
            cal_high_reg <= 10'd863;
            warn_reg     <= 8'd40;
            style_reg    <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fta_pkg::CFG_TIMER_CONDITION:  cond_reg     <= cfg_data[7:0];
                fta_pkg::CFG_ALARM_LIMIT:      limit_reg    <= cfg_data;
                fta_pkg::CFG_TIMER_PRESET:     preset_reg   <= cfg_data;
                fta_pkg::CFG_BATTERY_CAL_LOW:  cal_low_reg  <= cfg_data[9:0];
                fta_pkg::CFG_BATTERY_CAL_HIGH: cal_high_reg <= cfg_data[9:0];
                fta_pkg::CFG_VOLTAGE_WARNING:  warn_reg     <= cfg_data[7:0];
                fta_pkg::CFG_ALARM_BEEP_STYLE: style_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Timer gate (throttle percent or run switch), next timer and alarm values, beep flag
    always_comb
    begin
        thr_sum = 9'(in_data.throttle) + 9'sd100;
        pct     = {1'b0, thr_sum[7:1]};
        cond_ok = 1'b0;
        if (cond_reg >= 8'd1 && cond_reg <= COND_PCT_MAX)
            cond_ok = !thr_sum[8] && (pct >= cond_reg);
        else if (cond_reg == COND_RUN)
            cond_ok = in_data.run_switch;
        counting  = (timer_reg != 16'd0) && cond_ok;
        timer_dec = timer_reg - 16'd1;
        alarm_inc = alarm_reg + 8'd1;
        tbeep     = counting && (timer_dec <= limit_reg)
                    && (mod3_zero(alarm_inc) || alarm_inc == 8'd1);
        vc_dec    = vc_reg - 3'd1;
        cal_equal = (cal_high_reg == cal_low_reg);
    end

    assign status.need_div = (in_data.opcode == fta_pkg::OP_TICK) && (vc_dec == 3'd0)
                             && !cal_equal;
    assign status.div_last = (cnt_reg == DIV_LAST);

    // State update on accept
    always_comb
    begin
        timer_next = timer_reg;
        alarm_next = alarm_reg;
        vc_next    = vc_reg;
        if (cmd.accept)
        begin
            if (in_data.opcode == fta_pkg::OP_RELOAD)
                timer_next = preset_reg;
            else
            begin
                if (counting)
                begin
                    timer_next = timer_dec;
                    alarm_next = (timer_dec <= limit_reg) ? alarm_inc : 8'd0;
                end
                vc_next = (vc_dec == 3'd0) ? VC_RELOAD : vc_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= 16'd0;
            alarm_reg <= 8'd0;
            vc_reg    <= VC_RELOAD;
        end
        else
        begin
            timer_reg <= timer_next;
            alarm_reg <= alarm_next;
            vc_reg    <= vc_next;
        end
    end

    // Multiply: magnitudes of the scaled numerator and of the span
    always_comb
    begin
        diff     = $signed({1'b0, raw_reg}) - $signed({1'b0, cal_low_reg});
        den      = $signed({1'b0, cal_high_reg}) - $signed({1'b0, cal_low_reg});
        diff_mag = diff[10] ? DEN_W'(-diff) : diff[9:0];
        den_mag  = den[10] ? DEN_W'(-den) : den[9:0];
        prod     = NUM_W'(diff_mag) * SCALE;
    end

    // One restoring divide step
    always_comb
    begin
        trial = {rem_reg, nq_reg[NUM_W-1]};
        qbit  = (trial >= {1'b0, dm_reg});
    end

    // Finish: sign, offset, saturate, threshold compare
    always_comb
    begin
        qs = neg_reg ? -$signed({2'b00, nq_reg}) : $signed({2'b00, nq_reg});
        v  = qs + OFFSET;
        if (v > SAT_MAX)
            cv = 16'sh7FFF;
        else if (v < SAT_MIN)
            cv = -16'sh8000;
        else
            cv = v[15:0];
        warn10 = {1'b0, warn_reg, 3'b000} + {3'b000, warn_reg, 1'b0};
        vlow   = cv < $signed({4'b0000, warn10});
    end

    // Divider registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            raw_reg <= in_data.battery_raw;
        if (cmd.mul_load)
        begin
            nq_reg  <= prod;
            dm_reg  <= den_mag;
            rem_reg <= '0;
            neg_reg <= diff[10] ^ den[10];
        end
        else if (cmd.div_step)
        begin
            nq_reg  <= {nq_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? DEN_W'(trial - {1'b0, dm_reg}) : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.mul_load)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    // Pending result
    always_comb
    begin
        res_next = res_reg;
        if (cmd.accept)
        begin
            res_next                    = '0;
            res_next.timer_value        = timer_next;
            if (in_data.opcode == fta_pkg::OP_TICK)
            begin
                res_next.counting     = counting;
                res_next.timer_beep   = tbeep;
                res_next.beep_style   = tbeep ? style_reg : 8'd0;
                res_next.backlight_on = tbeep;
            end
        end
        else if (cmd.fin)
        begin
            res_next.voltage_checked    = 1'b1;
            res_next.voltage_low        = vlow;
            res_next.battery_centivolts = cv;
            res_next.beep_style   = (res_reg.timer_beep || vlow) ? style_reg : 8'd0;
            res_next.backlight_on = res_reg.timer_beep || vlow;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    assign out_data = out_reg;

endmodule

@@ sv/flight_timer_and_battery_alarm.sv @@
// Reloads and ticks without a battery check go from IDLE straight to PUSH. Every fifth tick,
// unless the two calibration points are equal, the battery check adds MUL, a 20-step serial
// divide and FIN. A request is taken only in IDLE, once the previous one is through.
// The next request is taken while the previous result waits in the output register.
// Reset (rst_n, asynchronous, active low): timer and alarm counter 0, check countdown 5,
// registers to their defaults (calibration 385/863, warning 40, beep style 1).
module flight_timer_and_battery_alarm (
    input  logic                 clk,
    input  logic                 rst_n,
    fta_item_if.sink             item,
    fta_result_if.source         result,
    fta_cfg_if.sink              cfg
);

    fta_pkg::ctrl_cmd_t  cmd;
    fta_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    // Sequencer
    fta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    fta_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (item.data),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_data  (result.data)
    );

`ifndef ASSERT_OFF
    // Not ready in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("request taken while previous one still in progress");

    // A low battery flag only comes with a check
    a_low_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.voltage_low |-> result.data.voltage_checked)
        else $error("voltage_low without voltage_checked");

    // A low battery always lights the backlight
    a_low_lights: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.voltage_low |-> result.data.backlight_on)
        else $error("voltage_low without backlight_on");

    // No voltage reported without a check
    a_cv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.voltage_checked
        |-> result.data.battery_centivolts == 16'sd0)
        else $error("centivolts nonzero on an unchecked tick");
`endif

endmodule
